// ===== rtl/qxm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X motor mixer package
// Shared widths, payload types and register indexes of the mixer.
// ----------------------------------------------------------------------------
package qxm_pkg;

  localparam int CMD_W  = 16;  // signed command width
  localparam int GAIN_W = 16;  // unsigned Q4.12 gain width
  localparam int OFS_W  = 12;  // signed pitch offset width
  localparam int LIM_W  = 15;  // motor limit and result width
  localparam int MOT_W  = 16;  // wrapped motor value width
  localparam int FRAC_W = 12;  // fraction bits of the gains
  localparam int PROD_W = 32;  // command times gain
  localparam int PAIR_W = 34;  // sum or difference of two scaled terms
  localparam int SUM_W  = 35;  // full mix in Q.12
  localparam int NUM_MOTORS = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_THROTTLE_GAIN = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROLL_GAIN     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PITCH_GAIN    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_YAW_GAIN      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PITCH_OFFSET  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT    = 3'd6;

  localparam logic [GAIN_W-1:0] THROTTLE_GAIN_RST = 16'd4096;
  localparam logic [GAIN_W-1:0] ROLL_GAIN_RST     = 16'd4096;
  localparam logic [GAIN_W-1:0] PITCH_GAIN_RST    = 16'd4506;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST      = 16'd4096;
  localparam logic [OFS_W-1:0]  PITCH_OFFSET_RST  = 12'hFB0;  // -80
  localparam logic [LIM_W-1:0]  LOW_LIMIT_RST     = 15'd200;
  localparam logic [LIM_W-1:0]  HIGH_LIMIT_RST    = 15'd1600;

  typedef struct packed {
    logic signed [CMD_W-1:0] throttle;
    logic signed [CMD_W-1:0] roll;
    logic signed [CMD_W-1:0] pitch;
    logic signed [CMD_W-1:0] yaw;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] throttle;
    logic [GAIN_W-1:0] roll;
    logic [GAIN_W-1:0] pitch;
    logic [GAIN_W-1:0] yaw;
  } gains_t;

  typedef struct packed {
    logic [LIM_W-1:0] lo;
    logic [LIM_W-1:0] hi;
  } limits_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] r;
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] y;
  } prod_t;

  typedef logic [MOT_W-1:0] motor_t;
  typedef motor_t [NUM_MOTORS-1:0] motors_t;
  typedef logic [LIM_W-1:0] result_t;
  typedef result_t [NUM_MOTORS-1:0] results_t;

endpackage

// ===== rtl/qxm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X motor mixer channel interfaces
// Command, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qxm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qxm_pkg::CMD_W-1:0]     throttle_cmd;
  logic signed [qxm_pkg::CMD_W-1:0]     roll_cmd;
  logic signed [qxm_pkg::CMD_W-1:0]     pitch_cmd;
  logic signed [qxm_pkg::CMD_W-1:0]     yaw_cmd;

  modport source (output valid, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd, input ready);
  modport sink   (input valid, throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd, output ready);
endinterface

interface qxm_out_if;
  logic                         valid;
  logic                         ready;
  logic [qxm_pkg::LIM_W-1:0]    motor_rear_right;
  logic [qxm_pkg::LIM_W-1:0]    motor_front_right;
  logic [qxm_pkg::LIM_W-1:0]    motor_rear_left;
  logic [qxm_pkg::LIM_W-1:0]    motor_front_left;

  modport source (output valid, motor_rear_right, motor_front_right, motor_rear_left,
                  motor_front_left, input ready);
  modport sink   (input valid, motor_rear_right, motor_front_right, motor_rear_left,
                  motor_front_left, output ready);
endinterface

interface qxm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qxm_pkg::CFG_ADDR_W-1:0]    addr;
  logic [qxm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/qxm_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X mixer gain stage
// Scales the four commands by their Q4.12 gains in one register stage.
// ----------------------------------------------------------------------------
module qxm_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qxm_pkg::cmd_t     in_cmd,
  input  qxm_pkg::gains_t   gains,
  output logic              out_valid,
  input  logic              out_ready,
  output qxm_pkg::prod_t    out_prod
);

  logic           valid_r;
  qxm_pkg::prod_t prod_r;
  qxm_pkg::prod_t prod_nxt;

  // Signed command times unsigned gain; the product always fits 32 bits.
  function automatic logic signed [qxm_pkg::PROD_W-1:0] scale(
    input logic signed [qxm_pkg::CMD_W-1:0] cmd,
    input logic [qxm_pkg::GAIN_W-1:0]       gain
  );
    logic signed [qxm_pkg::PROD_W:0] full;
    full = cmd * $signed({1'b0, gain});
    return full[qxm_pkg::PROD_W-1:0];
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    prod_nxt.t = scale(in_cmd.throttle, gains.throttle);
    prod_nxt.r = scale(in_cmd.roll, gains.roll);
    prod_nxt.p = scale(in_cmd.pitch, gains.pitch);
    prod_nxt.y = scale(in_cmd.yaw, gains.yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

// ===== rtl/qxm_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X mixer sum stages
// Forms the four X-frame mixes, then truncates and saturates them to int16.
// ----------------------------------------------------------------------------
module qxm_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  qxm_pkg::prod_t              in_prod,
  input  logic [qxm_pkg::OFS_W-1:0]   pitch_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output qxm_pkg::motors_t            out_motors
);

  typedef logic signed [qxm_pkg::PAIR_W-1:0] pair_t;
  typedef logic signed [qxm_pkg::SUM_W-1:0]  sum_t;
  typedef logic signed [qxm_pkg::SUM_W-qxm_pkg::FRAC_W-1:0] quot_t;

  // Stage A: throttle plus/minus pitch, roll plus/minus yaw.
  logic  a_valid_r;
  logic  a_ready;
  pair_t tpp_r, tmp_r, rpy_r, rmy_r;
  pair_t tpp_nxt, tmp_nxt, rpy_nxt, rmy_nxt;
  pair_t p_full;

  // Stage B: full mixes in Q.12.
  logic  b_valid_r;
  logic  b_ready;
  sum_t  [qxm_pkg::NUM_MOTORS-1:0] sum_r;
  sum_t  [qxm_pkg::NUM_MOTORS-1:0] sum_nxt;

  // Stage C: truncated and saturated motors.
  logic             c_valid_r;
  logic             c_ready;
  qxm_pkg::motors_t mot_r;
  qxm_pkg::motors_t mot_nxt;

  // Divide by 4096 toward zero, then saturate to the int16 range.
  function automatic qxm_pkg::motor_t trunc_sat(input sum_t s);
    quot_t q;
    q = s[qxm_pkg::SUM_W-1:qxm_pkg::FRAC_W];
    if (s[qxm_pkg::SUM_W-1] && (|s[qxm_pkg::FRAC_W-1:0])) begin
      q = q + quot_t'(1);
    end
    if (q > 32767) begin
      return 16'h7FFF;
    end else if (q < -32768) begin
      return 16'h8000;
    end else begin
      return q[qxm_pkg::MOT_W-1:0];
    end
  endfunction

  assign c_ready  = !c_valid_r || out_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    p_full  = pair_t'(in_prod.p) + (pair_t'($signed(pitch_offset)) <<< qxm_pkg::FRAC_W);
    tpp_nxt = pair_t'(in_prod.t) + p_full;
    tmp_nxt = pair_t'(in_prod.t) - p_full;
    rpy_nxt = pair_t'(in_prod.r) + pair_t'(in_prod.y);
    rmy_nxt = pair_t'(in_prod.r) - pair_t'(in_prod.y);
  end

  always_comb begin
    sum_nxt[0] = sum_t'(tmp_r) - sum_t'(rpy_r);  // T - P - R - Y
    sum_nxt[1] = sum_t'(tpp_r) - sum_t'(rmy_r);  // T + P - R + Y
    sum_nxt[2] = sum_t'(tmp_r) + sum_t'(rpy_r);  // T - P + R + Y
    sum_nxt[3] = sum_t'(tpp_r) + sum_t'(rmy_r);  // T + P + R - Y
  end

  always_comb begin
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      mot_nxt[i] = trunc_sat(sum_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      tpp_r <= tpp_nxt;
      tmp_r <= tmp_nxt;
      rpy_r <= rpy_nxt;
      rmy_r <= rmy_nxt;
    end
    if (b_ready && a_valid_r) begin
      sum_r <= sum_nxt;
    end
    if (c_ready && b_valid_r) begin
      mot_r <= mot_nxt;
    end
  end

  assign out_valid  = c_valid_r;
  assign out_motors = mot_r;

endmodule

// ===== rtl/qxm_limit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X mixer limit stages
// Shifts the motors down to the high limit, up to the low limit, then clamps.
// ----------------------------------------------------------------------------
module qxm_limit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qxm_pkg::motors_t     in_motors,
  input  qxm_pkg::limits_t     limits,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qxm_pkg::results_t    out_results
);

  logic              h_valid_r, l_valid_r, c_valid_r;
  logic              h_ready, l_ready, c_ready;
  qxm_pkg::motors_t  h_mot_r, h_mot_nxt;
  qxm_pkg::motors_t  l_mot_r, l_mot_nxt;
  qxm_pkg::results_t res_r, res_nxt;
  logic signed [qxm_pkg::MOT_W-1:0] hi_s, lo_s;

  // Each check sees the values already moved by the checks before it.
  function automatic qxm_pkg::motors_t pull_down(
    input qxm_pkg::motors_t                m,
    input logic signed [qxm_pkg::MOT_W-1:0] hi
  );
    qxm_pkg::motors_t r;
    qxm_pkg::motor_t  amt;
    r = m;
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      if ($signed(r[i]) > hi) begin
        amt = r[i] - hi;
        for (int j = 0; j < qxm_pkg::NUM_MOTORS; j++) begin
          r[j] = r[j] - amt;
        end
      end
    end
    return r;
  endfunction

  function automatic qxm_pkg::motors_t push_up(
    input qxm_pkg::motors_t                m,
    input logic signed [qxm_pkg::MOT_W-1:0] lo
  );
    qxm_pkg::motors_t r;
    qxm_pkg::motor_t  amt;
    r = m;
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      if ($signed(r[i]) < lo) begin
        amt = lo - r[i];
        for (int j = 0; j < qxm_pkg::NUM_MOTORS; j++) begin
          r[j] = r[j] + amt;
        end
      end
    end
    return r;
  endfunction

  assign hi_s = $signed({1'b0, limits.hi});
  assign lo_s = $signed({1'b0, limits.lo});

  assign c_ready  = !c_valid_r || out_ready;
  assign l_ready  = !l_valid_r || c_ready;
  assign h_ready  = !h_valid_r || l_ready;
  assign in_ready = h_ready;

  assign h_mot_nxt = pull_down(in_motors, hi_s);
  assign l_mot_nxt = push_up(h_mot_r, lo_s);

  // High clamp first, low clamp second: a low limit above the high one wins.
  always_comb begin
    logic signed [qxm_pkg::MOT_W-1:0] v;
    for (int i = 0; i < qxm_pkg::NUM_MOTORS; i++) begin
      v = $signed(l_mot_r[i]);
      if (v > hi_s) begin
        v = hi_s;
      end
      if (v < lo_s) begin
        v = lo_s;
      end
      res_nxt[i] = v[qxm_pkg::LIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
      l_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (h_ready) begin
        h_valid_r <= in_valid;
      end
      if (l_ready) begin
        l_valid_r <= h_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= l_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h_ready && in_valid) begin
      h_mot_r <= h_mot_nxt;
    end
    if (l_ready && h_valid_r) begin
      l_mot_r <= l_mot_nxt;
    end
    if (c_ready && l_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid   = c_valid_r;
  assign out_results = res_r;

endmodule

// ===== rtl/quad_x_motor_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad-X motor mixer
// Scales throttle, roll, pitch and yaw, mixes them into four X-frame motor
// commands and fits the motors into a programmable window.
// ----------------------------------------------------------------------------
// The mixer accepts one command transaction every clock cycle while the result
// side does not stall and returns one result transaction for each, in order.
// The pipeline has seven register stages: the gain multipliers, two adder
// stages that form the four mixes, the truncate-and-saturate stage, the
// pull-down pass to the high limit, the push-up pass to the low limit and the
// final clamp, whose register is the output register. Each stage holds its
// transaction while the stage after it is full and stalled, so back-pressure
// on the result channel pauses the whole pipeline without losing or repeating
// anything, and an empty stage always takes new data. Registers are written
// through the configuration channel, which is always ready; write them only
// while no transaction is in flight. An index beyond the high limit register
// is ignored.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer (
  input  logic       clk,
  input  logic       rst_n,
  qxm_in_if.sink     in_ch,
  qxm_out_if.source  out_ch,
  qxm_cfg_if.sink    cfg_ch
);

  // Configuration registers.
  qxm_pkg::gains_t               gains_r;
  logic [qxm_pkg::OFS_W-1:0]     pitch_offset_r;
  qxm_pkg::limits_t              limits_r;

  // Handshakes between the three pipeline sections.
  logic              mult_valid, mult_ready;
  qxm_pkg::prod_t    mult_prod;
  logic              mix_valid, mix_ready;
  qxm_pkg::motors_t  mix_motors;
  qxm_pkg::cmd_t     in_cmd;
  qxm_pkg::results_t results;

  assign cfg_ch.ready = 1'b1;

  // Each register keeps only the bits its field defines.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.throttle <= qxm_pkg::THROTTLE_GAIN_RST;
      gains_r.roll     <= qxm_pkg::ROLL_GAIN_RST;
      gains_r.pitch    <= qxm_pkg::PITCH_GAIN_RST;
      gains_r.yaw      <= qxm_pkg::YAW_GAIN_RST;
      pitch_offset_r   <= qxm_pkg::PITCH_OFFSET_RST;
      limits_r.lo      <= qxm_pkg::LOW_LIMIT_RST;
      limits_r.hi      <= qxm_pkg::HIGH_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        qxm_pkg::REG_THROTTLE_GAIN: gains_r.throttle <= cfg_ch.data;
        qxm_pkg::REG_ROLL_GAIN:     gains_r.roll     <= cfg_ch.data;
        qxm_pkg::REG_PITCH_GAIN:    gains_r.pitch    <= cfg_ch.data;
        qxm_pkg::REG_YAW_GAIN:      gains_r.yaw      <= cfg_ch.data;
        qxm_pkg::REG_PITCH_OFFSET:  pitch_offset_r   <= cfg_ch.data[qxm_pkg::OFS_W-1:0];
        qxm_pkg::REG_LOW_LIMIT:     limits_r.lo      <= cfg_ch.data[qxm_pkg::LIM_W-1:0];
        qxm_pkg::REG_HIGH_LIMIT:    limits_r.hi      <= cfg_ch.data[qxm_pkg::LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_cmd.throttle = in_ch.throttle_cmd;
  assign in_cmd.roll     = in_ch.roll_cmd;
  assign in_cmd.pitch    = in_ch.pitch_cmd;
  assign in_cmd.yaw      = in_ch.yaw_cmd;

  // Stage 1: gain multipliers.
  qxm_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_cmd),
    .gains     (gains_r),
    .out_valid (mult_valid),
    .out_ready (mult_ready),
    .out_prod  (mult_prod)
  );

  // Stages 2 to 4: mixing, truncation toward zero and int16 saturation.
  qxm_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mult_valid),
    .in_ready     (mult_ready),
    .in_prod      (mult_prod),
    .pitch_offset (pitch_offset_r),
    .out_valid    (mix_valid),
    .out_ready    (mix_ready),
    .out_motors   (mix_motors)
  );

  // Stages 5 to 7: shift passes with 16-bit wrap and the final clamp.
  qxm_limit u_limit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mix_valid),
    .in_ready    (mix_ready),
    .in_motors   (mix_motors),
    .limits      (limits_r),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_results (results)
  );

  assign out_ch.motor_rear_right  = results[0];
  assign out_ch.motor_front_right = results[1];
  assign out_ch.motor_rear_left   = results[2];
  assign out_ch.motor_front_left  = results[3];

endmodule
